// File: rtl/core/ewh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_pkg
// Shared widths, codes and defaults for the equal-width histogram block.
// ----------------------------------------------------------------------------
package ewh_pkg;

  // Default capacity of the count memory.
  localparam int MAX_BINS_DEF = 1024;

  // Field widths.
  localparam int SAMPLE_W = 32;
  localparam int START_W  = 32;
  localparam int WIDTH_W  = 16;
  localparam int NBINS_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 32;
  localparam int EDGE_W   = 33;

  // The offset of a sample from the range start needs one bit more than a sample.
  localparam int DIVIDEND_W = SAMPLE_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int PROD_W     = INDEX_W + WIDTH_W;

  // Stream packing.
  localparam int IN_DATA_W  = ((SAMPLE_W + INDEX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COUNT_W + EDGE_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_START = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BIN_WIDTH   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BIN_COUNT   = 2'd2;

  // Reset values of the registers.
  localparam logic [START_W-1:0] RANGE_START_RST = '0;
  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST   = 16'd1;
  localparam logic [NBINS_W-1:0] BIN_COUNT_RST   = 11'd1024;

  // Command codes carried in tuser.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

// File: rtl/core/equal_width_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_width_histogram
// Counts samples into equal-width bins and reads back single bin counts.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                        Word
//  in       in   in_tvalid/tready/tdata/tuser cmd, sample_value, bin_index
//  out      out  out_tvalid/tready/tdata/tuser bin_total, bin_lower_edge, flag
//  cfg      in   cfg_we/cfg_addr/cfg_wdata    range_start, bin_width, bin_count
//
//  An add word with a sample not below range_start and a nonzero bin_width
//  holds in_tready low in the divider state (33 quotient bits from the
//  bit-serial divider, then its done pulse) and, for a bin in range, while
//  the count is read and written. A read word waits in ST_RD_DONE while
//  the output word is unread. After reset the count memory is cleared one
//  entry a cycle with in_tready low. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module equal_width_histogram
  import ewh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_value, bin_index, zero pad
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // bin_total, bin_lower_edge, zero pad
  output logic                  out_tuser,  // index_invalid
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_BINS);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV     = 6'b000010,
    ST_INC_RD  = 6'b000100,
    ST_INC_WR  = 6'b001000,
    ST_RD_MUL  = 6'b010000,
    ST_RD_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [START_W-1:0] range_start_r;
  logic [WIDTH_W-1:0] bin_width_r;
  logic [NBINS_W-1:0] bin_count_r;
  logic [NBINS_W-1:0] used;

  logic [AW-1:0]      addr_r, addr_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_total_r, out_total_nxt;
  logic [EDGE_W-1:0]  out_edge_r, out_edge_nxt;
  logic               out_bad_r, out_bad_nxt;

  logic                  in_acc;
  logic                  in_cmd;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [INDEX_W-1:0]    in_index;
  logic [DIVIDEND_W-1:0] offset;

  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;

  logic               mem_we;
  logic [COUNT_W-1:0] mem_rd;
  logic               mem_busy;
  logic               rd_bad;

  ewh_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (offset),
    .divisor  (bin_width_r),
    .done     (div_done),
    .quotient (quotient)
  );

  ewh_count_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .addr    (addr_r),
    .wdata   (mem_rd + 1'b1),
    .rd_data (mem_rd),
    .busy    (mem_busy)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= RANGE_START_RST;
      bin_width_r   <= BIN_WIDTH_RST;
      bin_count_r   <= BIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RANGE_START: range_start_r <= cfg_wdata[START_W-1:0];
        REG_BIN_WIDTH:   bin_width_r   <= cfg_wdata[WIDTH_W-1:0];
        REG_BIN_COUNT:   bin_count_r   <= cfg_wdata[NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  assign used = ({21'b0, bin_count_r} > 32'(MAX_BINS)) ? NBINS_W'(MAX_BINS) : bin_count_r;

  assign in_tready = (state_r == ST_IDLE) && !mem_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = in_tuser;
  assign in_sample = in_tdata[SAMPLE_W-1:0];
  assign in_index  = in_tdata[SAMPLE_W +: INDEX_W];

  // Exact offset from the range start; the top bit is its sign.
  assign offset = {in_sample[SAMPLE_W-1], in_sample}
                - {range_start_r[START_W-1], range_start_r};

  assign rd_bad = ({1'b0, idx_r} >= used);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_total_nxt = out_total_r;
    out_edge_nxt  = out_edge_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_READ) begin
            idx_nxt   = in_index;
            addr_nxt  = AW'(in_index);
            state_nxt = ST_RD_MUL;
          end else if (!offset[DIVIDEND_W-1] && (bin_width_r != '0)) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (quotient < {{(DIVIDEND_W-NBINS_W){1'b0}}, used}) begin
            addr_nxt  = quotient[AW-1:0];
            state_nxt = ST_INC_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INC_RD: begin
        state_nxt = ST_INC_WR;
      end
      ST_INC_WR: begin
        // A count at its maximum stays there.
        mem_we    = (mem_rd != '1);
        state_nxt = ST_IDLE;
      end
      ST_RD_MUL: begin
        prod_nxt  = {{(PROD_W-INDEX_W){1'b0}}, idx_r}
                  * {{(PROD_W-WIDTH_W){1'b0}}, bin_width_r};
        state_nxt = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = rd_bad ? '0 : mem_rd;
          out_edge_nxt  = {range_start_r[START_W-1], range_start_r}
                        + {{(EDGE_W-PROD_W){1'b0}}, prod_r};
          out_bad_nxt   = rd_bad;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    idx_r       <= idx_nxt;
    prod_r      <= prod_nxt;
    out_total_r <= out_total_nxt;
    out_edge_r  <= out_edge_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-COUNT_W-EDGE_W){1'b0}}, out_edge_r, out_total_r};
  assign out_tuser  = out_bad_r;

endmodule

// File: rtl/core/ewh_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_divider
// Restoring divider, one quotient bit per cycle, for the sample offset.
// ----------------------------------------------------------------------------
module ewh_divider
  import ewh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [WIDTH_W-1:0]    divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WIDTH_W-1:0]    rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [WIDTH_W-1:0]    dvs_r, dvs_nxt;
  logic [WIDTH_W:0]      trial;
  logic [WIDTH_W:0]      diff;
  logic                  fits;

  // The dividend shifts out of quo_r from the top while quotient bits enter below.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/ewh_count_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_count_mem
// Bin count memory with a registered read port and a clearing pass after reset.
// ----------------------------------------------------------------------------
module ewh_count_mem
  import ewh_pkg::*;
#(
  parameter int DEPTH = MAX_BINS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic [COUNT_W-1:0] wdata,
  output logic [COUNT_W-1:0] rd_data,
  output logic               busy
);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_data_r;
  logic               clr_r, clr_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               wen;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] wval;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign wen   = clr_r | we;
  assign waddr = clr_r ? clr_addr_r : addr;
  assign wval  = clr_r ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wval;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_r;

endmodule
